// ----- src/hegd_pkg.sv -----
`timescale 1ns / 1ps
package hegd_pkg;

    localparam int NODES = 8;
    localparam int NODE_W = $clog2(NODES);
    localparam int DEFAULT_FRAC_BITS = 16;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam int PADDR_W = 3;
    localparam logic REG_DET_ONLY = 1'b0;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] deriv_xi;
        logic signed [31:0] deriv_eta;
        logic signed [31:0] deriv_zeta;
        logic signed [31:0] shape_in;
        logic               final_node;
    } hegd_in_t;

    typedef struct packed {
        logic [2:0]         node_number;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic signed [31:0] grad_z;
        logic signed [31:0] shape_out;
        logic signed [63:0] determinant;
        logic               inverted;
        logic               run_end;
    } hegd_out_t;

    typedef struct packed {
        logic [NODE_W-1:0] slot;
        hegd_in_t          data;
    } hegd_node_t;

    localparam logic [1:0] STEP_ROW [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] STEP_COL [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam logic [3:0] TRANSPOSE_IDX [9] =
        '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

    // Cofactor i is narrow(J[A1]*J[B1] - J[A2]*J[B2]).
    localparam logic [3:0] COF_A1 [9] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam logic [3:0] COF_B1 [9] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam logic [3:0] COF_A2 [9] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam logic [3:0] COF_B2 [9] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

endpackage

// ----- src/hegd_fifo.sv -----
`timescale 1ns / 1ps
module hegd_fifo
    import hegd_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  hegd_node_t push_word,
    output logic       full,
    input  logic       pop,
    output hegd_node_t head,
    output logic       empty
);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    hegd_node_t        entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- src/hegd_front.sv -----
`timescale 1ns / 1ps
module hegd_front
    import hegd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  hegd_in_t   in_data,
    output logic       push,
    output hegd_node_t push_word,
    input  logic       full
);
    logic [NODE_W-1:0] slot_reg;
    logic [NODE_W-1:0] slot_next;

    assign in_stall       = full;
    assign push           = in_valid && !full;
    assign push_word.slot = slot_reg;
    assign push_word.data = in_data;

    // The slot wraps after the last node; a final word starts a new run at slot zero.
    always_comb
    begin
        slot_next = slot_reg;
        if (push)
        begin
            if (in_data.final_node)
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

endmodule

// ----- src/hegd_back.sv -----
`timescale 1ns / 1ps
module hegd_back
    import hegd_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  hegd_node_t head,
    input  logic       empty,
    output logic       pop,
    input  logic       det_only_mode,
    output logic       out_valid,
    input  logic       out_stall,
    output hegd_out_t  out_data
);
    localparam int UP_W  = 2 * FRAC_BITS;
    localparam int DIV_W = 32 + UP_W;

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_NODE    = 13'b0000000000010,
        ST_DRAIN   = 13'b0000000000100,
        ST_NARROW  = 13'b0000000001000,
        ST_COF     = 13'b0000000010000,
        ST_CDRAIN  = 13'b0000000100000,
        ST_CHECK   = 13'b0000001000000,
        ST_DIV     = 13'b0000010000000,
        ST_DIVRUN  = 13'b0000100000000,
        ST_DIVEND  = 13'b0001000000000,
        ST_GRAD    = 13'b0010000000000,
        ST_GDRAIN  = 13'b0100000000000,
        ST_EMIT    = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        TG_JSUM,
        TG_COF,
        TG_DET,
        TG_GRAD
    } target_t;

    typedef struct packed {
        target_t    kind;
        logic       first;
        logic       sub;
        logic       last;
        logic [3:0] dst;
    } tag_t;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63])
        begin
            return {1'b0, {63{1'b1}}};
        end
        if (a[63] && b[63] && !s[63])
        begin
            return {1'b1, {63{1'b0}}};
        end
        return s;
    endfunction

    // Drops FRAC_BITS fraction bits, rounding half up, and saturates to 32 bits.
    function automatic logic signed [31:0] narrow(input logic signed [63:0] v);
        logic signed [63:0] sh;
        logic signed [64:0] q;
        sh = v >>> FRAC_BITS;
        q  = {sh[63], sh} + {64'd0, v[FRAC_BITS-1]};
        if (q > 65'sh0_7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        if (q < -65'sh0_8000_0000)
        begin
            return 32'sh8000_0000;
        end
        return q[31:0];
    endfunction

    state_t             state_reg;
    state_t             state_next;
    logic [4:0]         step_reg;
    logic [NODE_W-1:0]  n_reg;
    logic [NODE_W-1:0]  last_reg;
    logic               final_reg;
    logic [3:0]         div_idx_reg;
    logic [4:0]         div_cnt_reg;
    logic               short_reg;
    logic               inv_flag_reg;
    logic               tag_valid_reg;
    logic               out_valid_reg;
    logic signed [63:0] jsum_reg [9];

    hegd_in_t           node_reg;
    logic signed [31:0] deriv_mem [NODES][3];
    logic signed [31:0] shape_mem [NODES];
    logic signed [63:0] prod_reg;
    tag_t               tag_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] jn_reg [9];
    logic signed [31:0] cof_reg [9];
    logic signed [31:0] inv_reg [9];
    logic signed [31:0] grad_reg [3];
    logic signed [63:0] det_reg;
    logic [63:0]        rem_reg;
    logic [31:0]        low_reg;
    logic [31:0]        q_reg;
    logic               over_reg;
    logic               neg_reg;
    hegd_out_t          out_reg;

    logic               iss_valid;
    tag_t               iss_tag;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] acc_sum;
    logic               out_free;
    logic [1:0]         row;
    logic [1:0]         col;
    logic [3:0]         cof_sel;
    logic [4:0]         det_step;
    logic [1:0]         det_sel;

    logic [31:0]        div_mag;
    logic [DIV_W-1:0]   div_dividend;
    logic [UP_W-1:0]    div_upper;
    logic [64:0]        div_r2;
    logic [64:0]        div_det;
    logic [64:0]        div_diff;
    logic               div_ge;
    logic [32:0]        div_cap;
    logic [32:0]        div_qv;
    logic [32:0]        div_neg_qv;
    logic signed [31:0] div_result;

    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign row      = STEP_ROW[step_reg[3:0]];
    assign col      = STEP_COL[step_reg[3:0]];
    assign cof_sel  = TRANSPOSE_IDX[step_reg[4:1]];
    assign det_step = step_reg - 5'd18;
    assign det_sel  = det_step[1:0];

    // One shared multiplier; the product and its tag are registered and folded in next cycle.
    always_comb
    begin
        iss_valid = 1'b0;
        iss_tag   = '{kind: TG_JSUM, first: 1'b0, sub: 1'b0, last: 1'b0, dst: 4'd0};
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_NODE:
            begin
                iss_valid   = 1'b1;
                iss_tag.dst = step_reg[3:0];
                case (row)
                    2'd0:    mul_a = node_reg.coord_x;
                    2'd1:    mul_a = node_reg.coord_y;
                    default: mul_a = node_reg.coord_z;
                endcase
                case (col)
                    2'd0:    mul_b = node_reg.deriv_xi;
                    2'd1:    mul_b = node_reg.deriv_eta;
                    default: mul_b = node_reg.deriv_zeta;
                endcase
            end
            ST_COF:
            begin
                iss_valid = 1'b1;
                if (step_reg < 5'd18)
                begin
                    iss_tag.kind = TG_COF;
                    iss_tag.dst  = cof_sel;
                    if (!step_reg[0])
                    begin
                        iss_tag.first = 1'b1;
                        mul_a = jn_reg[COF_A1[cof_sel]];
                        mul_b = jn_reg[COF_B1[cof_sel]];
                    end
                    else
                    begin
                        iss_tag.sub  = 1'b1;
                        iss_tag.last = 1'b1;
                        mul_a = jn_reg[COF_A2[cof_sel]];
                        mul_b = jn_reg[COF_B2[cof_sel]];
                    end
                end
                else
                begin
                    iss_tag.kind  = TG_DET;
                    iss_tag.first = (det_sel == 2'd0);
                    iss_tag.last  = (det_sel == 2'd2);
                    mul_a = jn_reg[{2'd0, det_sel}];
                    mul_b = cof_reg[TRANSPOSE_IDX[{2'd0, det_sel}]];
                end
            end
            ST_GRAD:
            begin
                iss_valid     = 1'b1;
                iss_tag.kind  = TG_GRAD;
                iss_tag.first = (col == 2'd0);
                iss_tag.last  = (col == 2'd2);
                iss_tag.dst   = {2'd0, row};
                mul_a = deriv_mem[n_reg][col];
                mul_b = inv_reg[TRANSPOSE_IDX[step_reg[3:0]]];
            end
            default:
            begin
                iss_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (tag_reg.first)
        begin
            acc_sum = prod_reg;
        end
        else if (tag_reg.sub)
        begin
            acc_sum = acc_reg - prod_reg;
        end
        else
        begin
            acc_sum = sat_add(acc_reg, prod_reg);
        end
    end

    // Quotient of |cofactor| scaled by 2^(2F) over the determinant, one bit a cycle.
    always_comb
    begin
        div_mag      = cof_reg[div_idx_reg][31] ? 32'(-cof_reg[div_idx_reg])
                                                : cof_reg[div_idx_reg];
        div_dividend = {div_mag, {UP_W{1'b0}}};
        div_upper    = div_dividend[DIV_W-1:32];
        div_r2       = {rem_reg, low_reg[31]};
        div_det      = {1'b0, det_reg};
        div_diff     = div_r2 - div_det;
        div_ge       = (div_r2 >= div_det);
        div_cap      = neg_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        div_qv       = (over_reg || ({1'b0, q_reg} > div_cap)) ? div_cap : {1'b0, q_reg};
        div_neg_qv   = -div_qv;
        div_result   = neg_reg ? div_neg_qv[31:0] : div_qv[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    state_next = ST_NODE;
                end
            end
            ST_NODE:
            begin
                if (step_reg == 5'd8)
                begin
                    state_next = final_reg ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN:  state_next = ST_NARROW;
            ST_NARROW: state_next = ST_COF;
            ST_COF:
            begin
                if (step_reg == 5'd20)
                begin
                    state_next = ST_CDRAIN;
                end
            end
            ST_CDRAIN: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (det_reg <= 0 || det_only_mode)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:    state_next = ST_DIVRUN;
            ST_DIVRUN:
            begin
                if (div_cnt_reg == 5'd31)
                begin
                    state_next = ST_DIVEND;
                end
            end
            ST_DIVEND: state_next = (div_idx_reg == 4'd8) ? ST_GRAD : ST_DIV;
            ST_GRAD:
            begin
                if (step_reg == 5'd8)
                begin
                    state_next = ST_GDRAIN;
                end
            end
            ST_GDRAIN: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (short_reg || n_reg == last_reg) ? ST_IDLE : ST_GRAD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            n_reg         <= '0;
            last_reg      <= '0;
            final_reg     <= 1'b0;
            div_idx_reg   <= '0;
            div_cnt_reg   <= '0;
            short_reg     <= 1'b0;
            inv_flag_reg  <= 1'b0;
            tag_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                jsum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            tag_valid_reg <= iss_valid;
            if (tag_valid_reg && tag_reg.kind == TG_JSUM)
            begin
                jsum_reg[tag_reg.dst] <= sat_add(jsum_reg[tag_reg.dst], prod_reg);
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (!empty)
                    begin
                        final_reg <= head.data.final_node;
                        last_reg  <= head.slot;
                    end
                end
                ST_NODE, ST_COF, ST_GRAD:
                begin
                    step_reg <= (state_next == state_reg) ? step_reg + 1'b1 : 5'd0;
                end
                ST_NARROW:
                begin
                    step_reg <= '0;
                    for (int i = 0; i < 9; i++)
                    begin
                        jsum_reg[i] <= '0;
                    end
                end
                ST_CHECK:
                begin
                    short_reg    <= (det_reg <= 0) || det_only_mode;
                    inv_flag_reg <= (det_reg <= 0);
                    div_idx_reg  <= '0;
                    n_reg        <= '0;
                end
                ST_DIV:
                begin
                    div_cnt_reg <= '0;
                end
                ST_DIVRUN:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                ST_DIVEND:
                begin
                    div_idx_reg <= div_idx_reg + 1'b1;
                    step_reg    <= '0;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        n_reg    <= n_reg + 1'b1;
                        step_reg <= '0;
                    end
                end
                default:
                begin
                    step_reg <= step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        tag_reg  <= iss_tag;
        if (pop)
        begin
            node_reg                <= head.data;
            deriv_mem[head.slot][0] <= head.data.deriv_xi;
            deriv_mem[head.slot][1] <= head.data.deriv_eta;
            deriv_mem[head.slot][2] <= head.data.deriv_zeta;
            shape_mem[head.slot]    <= head.data.shape_in;
        end
        if (tag_valid_reg && tag_reg.kind != TG_JSUM)
        begin
            acc_reg <= acc_sum;
            if (tag_reg.last)
            begin
                case (tag_reg.kind)
                    TG_COF:  cof_reg[tag_reg.dst] <= narrow(acc_sum);
                    TG_DET:  det_reg <= acc_sum;
                    TG_GRAD: grad_reg[tag_reg.dst[1:0]] <= narrow(acc_sum);
                    default: acc_reg <= acc_sum;
                endcase
            end
        end
        if (state_reg == ST_NARROW)
        begin
            for (int i = 0; i < 9; i++)
            begin
                jn_reg[i] <= narrow(jsum_reg[i]);
            end
        end
        if (state_reg == ST_DIV)
        begin
            neg_reg  <= cof_reg[div_idx_reg][31];
            over_reg <= (64'(div_upper) >= det_reg);
            rem_reg  <= 64'(div_upper);
            low_reg  <= div_dividend[31:0];
            q_reg    <= '0;
        end
        if (state_reg == ST_DIVRUN)
        begin
            rem_reg <= div_ge ? div_diff[63:0] : div_r2[63:0];
            low_reg <= {low_reg[30:0], 1'b0};
            q_reg   <= {q_reg[30:0], div_ge};
        end
        if (state_reg == ST_DIVEND)
        begin
            inv_reg[div_idx_reg] <= div_result;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_reg.determinant <= det_reg;
            out_reg.inverted    <= inv_flag_reg;
            if (short_reg)
            begin
                out_reg.node_number <= '0;
                out_reg.grad_x      <= '0;
                out_reg.grad_y      <= '0;
                out_reg.grad_z      <= '0;
                out_reg.shape_out   <= '0;
                out_reg.run_end     <= 1'b1;
            end
            else
            begin
                out_reg.node_number <= 3'(n_reg);
                out_reg.grad_x      <= grad_reg[0];
                out_reg.grad_y      <= grad_reg[1];
                out_reg.grad_z      <= grad_reg[2];
                out_reg.shape_out   <= shape_mem[n_reg];
                out_reg.run_end     <= (n_reg == last_reg);
            end
        end
    end

endmodule

// ----- src/hex_element_global_derivatives.sv -----
`timescale 1ns / 1ps
// Channel  Handshake                 Word
// in       in_valid / in_stall       hegd_in_t: one node of the element
// out      out_valid / out_stall     hegd_out_t: one node's gradients or the determinant
// cfg      psel, penable, pwrite     det_only_mode at byte address 0
//
// A node that does not close a run only accumulates the Jacobian in the back end (one shared multiplier).
// A final node adds the cofactors and determinant; full mode then adds
// 9 divisions and a gradient pass per emitted node.
// Reset clears the node counter, the Jacobian sums and det_only_mode; no clearing pass is needed.
// A short queue lets nodes be taken while the back end works or out_stall holds a word.
module hex_element_global_derivatives
    import hegd_pkg::*;
#(
    parameter int FRAC_BITS   = DEFAULT_FRAC_BITS,
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  hegd_in_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output hegd_out_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic       det_only_reg;
    logic       push;
    hegd_node_t push_word;
    logic       full;
    logic       pop;
    hegd_node_t head;
    logic       empty;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DET_ONLY) ? {31'd0, det_only_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_only_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_DET_ONLY)
        begin
            det_only_reg <= pwdata[0];
        end
    end

    hegd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .push      (push),
        .push_word (push_word),
        .full      (full)
    );

    hegd_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    hegd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .det_only_mode (det_only_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data)
    );

endmodule

// ----- verif/hegd_checker.sv -----
`timescale 1ns / 1ps
module hegd_checker
    import hegd_pkg::*;
#(
    parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  hegd_in_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  hegd_out_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 pending
);

    localparam longint MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint MIN64 = 64'sh8000_0000_0000_0000;

    logic signed [31:0] node_coord [24];
    logic signed [31:0] node_deriv [24];
    logic signed [31:0] node_shape [8];
    longint             jac_sum [9];
    int unsigned        slot_ctr;
    logic               det_only;
    hegd_out_t          expected_words [$];

    function automatic longint sat_sum(longint a, longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? MIN64 : MAX64;
        return s;
    endfunction

    function automatic longint round_q(longint v);
        longint q;
        q = v >>> FRAC_BITS;
        if (v[FRAC_BITS-1])
            q = q + 1;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        return q;
    endfunction

    function automatic longint inverse_entry(longint cof, longint det);
        logic [127:0] num;
        logic [127:0] quo;
        logic [63:0]  mag;
        logic [127:0] cap;
        mag = (cof >= 0) ? cof : -cof;
        cap = (cof >= 0) ? 128'h7FFF_FFFF : 128'h8000_0000;
        num = {64'd0, mag} << (2 * FRAC_BITS);
        quo = num / {64'd0, det};
        if (quo > cap)
            quo = cap;
        return (cof >= 0) ? longint'(quo[63:0]) : -longint'(quo[63:0]);
    endfunction

    function automatic longint mul(longint a, longint b);
        return a * b;
    endfunction

    task automatic predict_node(hegd_in_t w);
        int unsigned slot;
        int unsigned count;
        longint jm [9];
        longint cof [9];
        longint inv [9];
        longint det;
        longint g [3];
        hegd_out_t r;
        slot = slot_ctr % NODES;
        node_coord[slot*3]   = w.coord_x;
        node_coord[slot*3+1] = w.coord_y;
        node_coord[slot*3+2] = w.coord_z;
        node_deriv[slot*3]   = w.deriv_xi;
        node_deriv[slot*3+1] = w.deriv_eta;
        node_deriv[slot*3+2] = w.deriv_zeta;
        node_shape[slot]     = w.shape_in;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                jac_sum[3*i+k] = sat_sum(jac_sum[3*i+k],
                    mul(longint'(node_coord[slot*3+i]), longint'(node_deriv[slot*3+k])));
        if (!w.final_node)
        begin
            slot_ctr = (slot + 1) % NODES;
            return;
        end
        count = slot + 1;
        for (int i = 0; i < 9; i++)
        begin
            jm[i] = round_q(jac_sum[i]);
            jac_sum[i] = 0;
        end
        slot_ctr = 0;
        for (int i = 0; i < 9; i++)
            cof[i] = round_q(mul(jm[COF_A1[i]], jm[COF_B1[i]])
                           - mul(jm[COF_A2[i]], jm[COF_B2[i]]));
        det = sat_sum(sat_sum(mul(jm[0], cof[0]), mul(jm[1], cof[3])), mul(jm[2], cof[6]));
        r = '0;
        r.determinant = det;
        r.run_end = 1'b1;
        if (det <= 0 || det_only)
        begin
            r.inverted = (det <= 0);
            expected_words.push_back(r);
            return;
        end
        for (int i = 0; i < 9; i++)
            inv[i] = inverse_entry(cof[i], det);
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 3; k++)
                g[k] = round_q(sat_sum(sat_sum(
                    mul(longint'(node_deriv[n*3]), inv[k]),
                    mul(longint'(node_deriv[n*3+1]), inv[3+k])),
                    mul(longint'(node_deriv[n*3+2]), inv[6+k])));
            r.node_number = n[2:0];
            r.grad_x = g[0][31:0];
            r.grad_y = g[1][31:0];
            r.grad_z = g[2][31:0];
            r.shape_out = node_shape[n];
            r.run_end = (n + 1 == count);
            expected_words.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hegd_out_t want;
        if (!rst_n)
        begin
            jac_sum = '{default: 0};
            slot_ctr = 0;
            det_only = 1'b0;
            expected_words.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_DET_ONLY)
                det_only = pwdata[0];
            if (in_valid && !in_stall)
                predict_node(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("%0t: unexpected word %p", $realtime, out_data);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.node_number !== want.node_number
                        || out_data.grad_x !== want.grad_x
                        || out_data.grad_y !== want.grad_y
                        || out_data.grad_z !== want.grad_z
                        || out_data.shape_out !== want.shape_out
                        || out_data.determinant !== want.determinant
                        || out_data.inverted !== want.inverted
                        || out_data.run_end !== want.run_end)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, out_data);
                    end
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import hegd_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    hegd_in_t           in_data;
    logic               out_valid;
    logic               out_stall;
    hegd_out_t          out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 tx_idle;
    int                 rx_idle;
    int                 sent;

    hex_element_global_derivatives u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hegd_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle);

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_node(hegd_in_t w);
        bit taken;
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        taken = 0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic write_mode(logic value);
        bit done;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(REG_DET_ONLY);
        pwdata <= {31'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        done = 0;
        while (!done)
        begin
            @(negedge clk);
            done = pready;
            @(posedge clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [31:0] jitter(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    // Nodes of a distorted brick around its centre; mirrored when flip is set, pure noise when full_noise is set.
    task automatic brick_run(int count, bit flip, bit full_noise);
        int sx;
        int sy;
        int sz;
        int ox;
        int s;
        hegd_in_t w;
        sx = $urandom_range(32'h80000, 32'h1000);
        sy = $urandom_range(32'h80000, 32'h1000);
        sz = $urandom_range(32'h80000, 32'h1000);
        ox = jitter(32'h100000);
        if (flip)
            sx = -sx;
        for (int n = 0; n < count; n++)
        begin
            s = n % 8;
            w.coord_x    = ((s & 1) ? sx : -sx) + ox + jitter(32'h400);
            w.coord_y    = ((s & 2) ? sy : -sy) + jitter(32'h400);
            w.coord_z    = ((s & 4) ? sz : -sz) + jitter(32'h400);
            w.deriv_xi   = ((s & 1) ? 32'sh2000 : -32'sh2000) + jitter(64);
            w.deriv_eta  = ((s & 2) ? 32'sh2000 : -32'sh2000) + jitter(64);
            w.deriv_zeta = ((s & 4) ? 32'sh2000 : -32'sh2000) + jitter(64);
            w.shape_in   = $urandom;
            if (full_noise)
                w[224:1] = {$urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom};
            w.final_node = (n == count - 1);
            push_node(w);
        end
    endtask

    task automatic random_phase(int quota);
        int pick;
        int stop;
        stop = sent + quota;
        while (sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                brick_run(8, $urandom_range(5) == 0, 1'b0);
            else if (pick < 80)
                brick_run($urandom_range(7, 1), 1'b0, 1'b0);
            else if (pick < 90)
                brick_run(8, 1'b0, 1'b1);
            else
                brick_run($urandom_range(12, 9), 1'b0, 1'b0);
        end
    endtask

    initial
    begin
        hegd_in_t w;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        out_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        tx_idle = 13;
        rx_idle = 47;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_mode(1'b0);
        brick_run(8, 1'b0, 1'b0);
        brick_run(3, 1'b0, 1'b0);
        brick_run(8, 1'b1, 1'b0);
        w = '1;
        w[224:1] = {7{32'h7FFF_FFFF}};
        w.final_node = 1'b0;
        push_node(w);
        w[224:1] = {7{32'h8000_0000}};
        w.final_node = 1'b1;
        push_node(w);
        w = '0;
        w.final_node = 1'b1;
        push_node(w);
        random_phase(35);
        drain();

        tx_idle = 47;
        rx_idle = 13;
        write_mode(1'b1);
        random_phase(30);
        drain();

        tx_idle = 0;
        rx_idle = 0;
        write_mode(1'b0);
        random_phase(35);
        drain();

        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
